/* src/dic_pkg.sv */
// Shared types, widths and constants of the discomfort index classifier.
// Holds the comfort band and unit codes, the result record and the threshold tables.
// No dependencies.
`default_nettype none

package dic_pkg;

  localparam int NSTAGE = 12;

  localparam int TEMP_W = 10;
  localparam int HUM_W  = 7;
  localparam int DI_W   = 10;
  localparam int BAND_W = 3;
  localparam int TRED_W = 11;
  localparam int HRED_W = 9;
  localparam int HQ_W   = 7;

  localparam logic [HUM_W-1:0] HUM_MAX = 7'd100;

  // Reciprocals for division by 9, 125 and 5 (shifts of 16, 24 and 16).
  localparam int unsigned RECIP9   = 7282;
  localparam int unsigned RECIP125 = 134217;
  localparam int unsigned RECIP5   = 13108;

  typedef enum logic [BAND_W-1:0] {
    BAND_NONE       = 3'd0,
    BAND_UNDER_HALF = 3'd1,
    BAND_OVER_HALF  = 3'd2,
    BAND_MOST       = 3'd3,
    BAND_ALL        = 3'd4,
    BAND_EMERGENCY  = 3'd5
  } band_t;

  typedef enum logic {
    UNIT_CELSIUS    = 1'b0,
    UNIT_FAHRENHEIT = 1'b1
  } unit_t;

  typedef struct packed {
    logic signed [10:0] di;
    band_t              band;
    logic               rv;
    logic signed [10:0] tred;
    logic [HUM_W-1:0]   rh;
  } dic_res_t;

  // Whole-degree temperature at which the index reaches 21 for a given humidity.
  function automatic logic [4:0] t21_of(logic [HUM_W-1:0] rh);
    logic [4:0] r;
    if (rh <= 7'd5) begin
      r = 5'd28;
    end else if (rh <= 7'd12) begin
      r = 5'd27;
    end else if (rh <= 7'd20) begin
      r = 5'd26;
    end else if (rh <= 7'd30) begin
      r = 5'd25;
    end else if (rh <= 7'd42) begin
      r = 5'd24;
    end else if (rh <= 7'd57) begin
      r = 5'd23;
    end else if (rh <= 7'd75) begin
      r = 5'd22;
    end else begin
      r = 5'd21;
    end
    return r;
  endfunction

  function automatic band_t band_of(logic signed [10:0] di);
    band_t b;
    if (di <= 11'sd21) begin
      b = BAND_NONE;
    end else if (di < 11'sd24) begin
      b = BAND_UNDER_HALF;
    end else if (di < 11'sd27) begin
      b = BAND_OVER_HALF;
    end else if (di < 11'sd29) begin
      b = BAND_MOST;
    end else if (di < 11'sd32) begin
      b = BAND_ALL;
    end else begin
      b = BAND_EMERGENCY;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

/* src/dic_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on dic_pkg for the field widths.
`default_nettype none

interface dic_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [dic_pkg::TEMP_W-1:0]   temperature;
  logic        [dic_pkg::HUM_W-1:0]    humidity;

  modport source (output valid, output temperature, output humidity, input ready);
  modport sink (input valid, input temperature, input humidity, output ready);
endinterface

interface dic_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dic_pkg::DI_W-1:0]     discomfort_index;
  logic        [dic_pkg::BAND_W-1:0]   comfort_band;
  logic                                reduce_valid;
  logic signed [dic_pkg::TRED_W-1:0]   temperature_reduction;
  logic signed [dic_pkg::HRED_W-1:0]   humidity_reduction;

  modport source (output valid, output discomfort_index, output comfort_band,
                  output reduce_valid, output temperature_reduction,
                  output humidity_reduction, input ready);
  modport sink (input valid, input discomfort_index, input comfort_band,
                input reduce_valid, input temperature_reduction,
                input humidity_reduction, output ready);
endinterface

`default_nettype wire

/* src/dic_pipe_ctrl.sv */
// Valid bits and per-stage load enables of the request pipeline.
// Depends on dic_pkg for the stage count.
`default_nettype none

module dic_pipe_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        out_ready,
  output logic [dic_pkg::NSTAGE-1:0]       en,
  output logic                             in_ready,
  output logic                             out_valid
);

  localparam int NS = dic_pkg::NSTAGE;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;

  // A stage loads when it or some stage after it is empty, or the result is taken.
  for (genvar g = 0; g < NS; g++) begin : g_en
    localparam logic [NS-1:0] LOW = {NS{1'b1}} >> (NS - g);
    assign en[g] = out_ready | ~(&(v_r | LOW));
  end

  always_comb begin
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int i = 1; i < NS; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];

endmodule

`default_nettype wire

/* src/dic_tconv.sv */
// Stages one and two: humidity clamp and Fahrenheit to Celsius conversion.
// Depends on dic_pkg for widths, unit codes and the reciprocal of nine.
`default_nettype none

module dic_tconv (
  input  wire logic                              clk,
  input  wire logic [dic_pkg::NSTAGE-1:0]        en,
  input  wire dic_pkg::unit_t                    unit_mode,
  input  wire logic signed [dic_pkg::TEMP_W-1:0] temperature,
  input  wire logic [dic_pkg::HUM_W-1:0]         humidity,
  output logic signed [dic_pkg::TEMP_W-1:0]      t_o,
  output logic [dic_pkg::HUM_W-1:0]              rh_o
);

  logic signed [10:0] diff;
  logic signed [12:0] dx;
  logic signed [12:0] f5;
  logic signed [12:0] f5n;
  logic [11:0]        fmag_nxt;

  logic signed [9:0]  s1_traw_r;
  logic [6:0]         s1_rh_r;
  logic               s1_fneg_r;
  logic [11:0]        s1_fmag_r;

  logic [24:0]        fp;
  logic signed [9:0]  fq;
  logic signed [9:0]  tf;
  logic signed [9:0]  t_nxt;

  logic signed [9:0]  s2_t_r;
  logic [6:0]         s2_rh_r;

  assign diff     = $signed({temperature[9], temperature}) - 11'sd32;
  assign dx       = {{2{diff[10]}}, diff};
  assign f5       = (dx <<< 2) + dx;
  assign f5n      = -f5;
  assign fmag_nxt = f5[12] ? f5n[11:0] : f5[11:0];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_traw_r <= temperature;
      s1_rh_r   <= (humidity > dic_pkg::HUM_MAX) ? dic_pkg::HUM_MAX : humidity;
      s1_fneg_r <= f5[12];
      s1_fmag_r <= fmag_nxt;
    end
  end

  assign fp    = 25'(s1_fmag_r) * 25'(dic_pkg::RECIP9);
  assign fq    = $signed({1'b0, fp[24:16]});
  assign tf    = s1_fneg_r ? -fq : fq;
  assign t_nxt = (unit_mode == dic_pkg::UNIT_FAHRENHEIT) ? tf : s1_traw_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_t_r  <= t_nxt;
      s2_rh_r <= s1_rh_r;
    end
  end

  assign t_o  = s2_t_r;
  assign rh_o = s2_rh_r;

endmodule

`default_nettype wire

/* src/dic_index.sv */
// Stages three to eleven: discomfort index, band and temperature reduction.
// Also forms the humidity quotient operands. Depends on dic_pkg.
`default_nettype none

module dic_index (
  input  wire logic                              clk,
  input  wire logic [dic_pkg::NSTAGE-1:0]        en,
  input  wire dic_pkg::unit_t                    unit_mode,
  input  wire logic signed [dic_pkg::TEMP_W-1:0] t_i,
  input  wire logic [dic_pkg::HUM_W-1:0]         rh_i,
  output logic signed [20:0]                     div_n,
  output logic signed [14:0]                     div_d,
  output dic_pkg::dic_res_t                      res_o
);

  // Stage 3
  logic signed [11:0] d;
  logic [6:0]         h;
  logic signed [19:0] prod_full;
  logic signed [21:0] n_full;
  logic signed [15:0] ddx;
  logic signed [15:0] dd;
  logic signed [9:0]  s3_t_r;
  logic [6:0]         s3_rh_r;
  logic signed [17:0] s3_prod_r;
  logic signed [20:0] s3_n_r;
  logic signed [14:0] s3_d_r;
  logic [4:0]         s3_t21_r;

  // Stage 4
  logic signed [22:0] tx23;
  logic signed [22:0] px23;
  logic signed [22:0] num;
  logic signed [22:0] s4_num_r;
  logic signed [9:0]  s4_t_r;
  logic [6:0]         s4_rh_r;
  logic [4:0]         s4_t21_r;

  // Stage 5
  logic signed [22:0] numn;
  logic [21:0]        s5_mag_r;
  logic               s5_neg_r;
  logic signed [9:0]  s5_t_r;
  logic [6:0]         s5_rh_r;
  logic [4:0]         s5_t21_r;

  // Stage 6
  logic [16:0]        y;
  logic [34:0]        yp;
  logic [16:0]        s6_y_r;
  logic [10:0]        s6_q0_r;
  logic               s6_neg_r;
  logic signed [9:0]  s6_t_r;
  logic [6:0]         s6_rh_r;
  logic [4:0]         s6_t21_r;

  // Stage 7
  logic [17:0]        r;
  logic [10:0]        q;
  logic signed [10:0] qs;
  logic signed [10:0] s7_di_r;
  logic signed [9:0]  s7_t_r;
  logic [6:0]         s7_rh_r;
  logic [4:0]         s7_t21_r;

  // Stages 8 to 11
  dic_pkg::dic_res_t  res8_nxt;
  dic_pkg::dic_res_t  s8_res_r;
  logic signed [13:0] tx14;
  logic signed [13:0] m9;
  dic_pkg::dic_res_t  s9_res_r;
  logic signed [13:0] s9_m9_r;
  logic signed [13:0] m9n;
  dic_pkg::dic_res_t  s10_res_r;
  logic [12:0]        s10_mag_r;
  logic               s10_neg_r;
  logic [26:0]        mp;
  logic signed [10:0] mq;
  logic signed [10:0] tf;
  dic_pkg::dic_res_t  res11_nxt;
  dic_pkg::dic_res_t  s11_res_r;

  assign d         = $signed({t_i[9], t_i, 1'b0}) - 12'sd29;
  assign h         = dic_pkg::HUM_MAX - rh_i;
  assign prod_full = $signed({{8{d[11]}}, d}) * $signed({13'b0, h});
  assign n_full    = 22'sd52100 - $signed({{12{t_i[9]}}, t_i}) * 22'sd1800;
  assign ddx       = {{4{d[11]}}, d};
  assign dd        = (ddx <<< 3) + (ddx <<< 1) + ddx;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_t_r    <= t_i;
      s3_rh_r   <= rh_i;
      s3_prod_r <= prod_full[17:0];
      s3_n_r    <= n_full[20:0];
      s3_d_r    <= dd[14:0];
      s3_t21_r  <= dic_pkg::t21_of(rh_i);
    end
  end

  assign div_n = s3_n_r;
  assign div_d = s3_d_r;

  assign tx23 = {{13{s3_t_r[9]}}, s3_t_r};
  assign px23 = {{5{s3_prod_r[17]}}, s3_prod_r};
  assign num  = tx23 * 23'sd4000 - px23 * 23'sd11;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_num_r <= num;
      s4_t_r   <= s3_t_r;
      s4_rh_r  <= s3_rh_r;
      s4_t21_r <= s3_t21_r;
    end
  end

  assign numn = -s4_num_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_mag_r <= s4_num_r[22] ? numn[21:0] : s4_num_r[21:0];
      s5_neg_r <= s4_num_r[22];
      s5_t_r   <= s4_t_r;
      s5_rh_r  <= s4_rh_r;
      s5_t21_r <= s4_t21_r;
    end
  end

  // Division by 4000 is a shift by five and a division by 125.
  assign y  = s5_mag_r[21:5];
  assign yp = 35'(y) * 35'(dic_pkg::RECIP125);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_y_r   <= y;
      s6_q0_r  <= yp[34:24];
      s6_neg_r <= s5_neg_r;
      s6_t_r   <= s5_t_r;
      s6_rh_r  <= s5_rh_r;
      s6_t21_r <= s5_t21_r;
    end
  end

  // The reciprocal estimate is at most one low.
  assign r  = 18'(s6_y_r) - 18'(s6_q0_r) * 18'd125;
  assign q  = s6_q0_r + 11'(r >= 18'd125);
  assign qs = $signed(q);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_di_r  <= s6_neg_r ? -qs : qs;
      s7_t_r   <= s6_t_r;
      s7_rh_r  <= s6_rh_r;
      s7_t21_r <= s6_t21_r;
    end
  end

  always_comb begin
    res8_nxt.di   = s7_di_r;
    res8_nxt.band = dic_pkg::band_of(s7_di_r);
    res8_nxt.rv   = s7_di_r > 11'sd21;
    res8_nxt.tred = $signed({s7_t_r[9], s7_t_r}) - $signed({6'b0, s7_t21_r});
    res8_nxt.rh   = s7_rh_r;
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s8_res_r <= res8_nxt;
    end
  end

  assign tx14 = {{3{s8_res_r.tred[10]}}, s8_res_r.tred};
  assign m9   = (tx14 <<< 3) + tx14;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s9_res_r <= s8_res_r;
      s9_m9_r  <= m9;
    end
  end

  assign m9n = -s9_m9_r;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s10_res_r <= s9_res_r;
      s10_mag_r <= s9_m9_r[13] ? m9n[12:0] : s9_m9_r[12:0];
      s10_neg_r <= s9_m9_r[13];
    end
  end

  assign mp = 27'(s10_mag_r) * 27'(dic_pkg::RECIP5);
  assign mq = $signed({1'b0, mp[25:16]});
  assign tf = s10_neg_r ? -mq : mq;

  always_comb begin
    res11_nxt = s10_res_r;
    if (unit_mode == dic_pkg::UNIT_FAHRENHEIT) begin
      res11_nxt.tred = tf;
    end
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s11_res_r <= res11_nxt;
    end
  end

  assign res_o = s11_res_r;

endmodule

`default_nettype wire

/* src/dic_hdiv.sv */
// Stages four to eleven: pipelined restoring divider for the humidity at index 21.
// One quotient bit per stage. Depends on dic_pkg for the quotient width.
`default_nettype none

module dic_hdiv (
  input  wire logic                       clk,
  input  wire logic [dic_pkg::NSTAGE-1:0] en,
  input  wire logic signed [20:0]         div_n,
  input  wire logic signed [14:0]         div_d,
  output logic [dic_pkg::HQ_W-1:0]        q_mag,
  output logic                            q_neg
);

  localparam int STEPS = dic_pkg::HQ_W;
  localparam int STG   = 4;

  logic signed [20:0]        nn;
  logic [19:0]               rem_r [STEPS];
  logic [13:0]               dm_r  [STEPS];
  logic                      neg_r [STEPS+1];
  logic [dic_pkg::HQ_W-1:0]  q_r   [1:STEPS];

  assign nn = -div_n;

  // The divisor is positive whenever the quotient is used.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      rem_r[0] <= div_n[20] ? nn[19:0] : div_n[19:0];
      dm_r[0]  <= div_d[13:0];
      neg_r[0] <= div_n[20];
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int B = STEPS - 1 - k;
    logic [20:0]              sub;
    logic [20:0]              trial;
    logic                     ge;
    logic [dic_pkg::HQ_W-1:0] q_in;
    logic [dic_pkg::HQ_W-1:0] q_nxt;

    assign sub   = 21'(dm_r[k]) << B;
    assign trial = {1'b0, rem_r[k]} - sub;
    assign ge    = ~trial[20];

    if (k == 0) begin : g_first
      assign q_in = '0;
    end else begin : g_next
      assign q_in = q_r[k];
    end

    always_comb begin
      q_nxt    = q_in;
      q_nxt[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (en[STG + k]) begin
        q_r[k+1]   <= q_nxt;
        neg_r[k+1] <= neg_r[k];
      end
    end

    if (k < STEPS - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en[STG + k]) begin
          rem_r[k+1] <= ge ? trial[19:0] : rem_r[k];
          dm_r[k+1]  <= dm_r[k];
        end
      end
    end
  end

  assign q_mag = q_r[STEPS];
  assign q_neg = neg_r[STEPS];

endmodule

`default_nettype wire

/* src/discomfort_index_classifier.sv */
// Top level of the discomfort index classifier: channels, unit register, output stage.
// Depends on dic_pkg, dic_if, dic_pipe_ctrl, dic_tconv, dic_index and dic_hdiv.
//
// The block takes one request per clock while no stall holds the input and returns one
// result per request, in order. The depth is set by the seven-stage restoring divider
// for the humidity reduction, which runs beside the index and temperature path and
// joins it in the output register. Each stage holds when it and the stages after it
// are full and the result is not taken, so bubbles close up and requests keep
// entering while a result waits, until every stage is full.
// cfg_wr_data selects Celsius (0) or Fahrenheit (1); change it only while idle.
`default_nettype none

module discomfort_index_classifier (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dic_in_if.sink     in_chan,
  dic_out_if.source  out_chan,
  input  wire logic  cfg_wr_en,
  input  wire logic  cfg_wr_data
);

  logic [dic_pkg::NSTAGE-1:0]      en;
  logic                            out_valid;
  dic_pkg::unit_t                  unit_mode_r;
  logic signed [dic_pkg::TEMP_W-1:0] t2;
  logic [dic_pkg::HUM_W-1:0]       rh2;
  logic signed [20:0]              div_n;
  logic signed [14:0]              div_d;
  dic_pkg::dic_res_t               res;
  logic [dic_pkg::HQ_W-1:0]        h_mag;
  logic                            h_neg;
  logic [8:0]                      rh9;
  logic [8:0]                      hm9;
  logic [8:0]                      hred;

  logic signed [dic_pkg::DI_W-1:0]   di_r;
  dic_pkg::band_t                    band_r;
  logic                              rv_r;
  logic signed [dic_pkg::TRED_W-1:0] tred_r;
  logic signed [dic_pkg::HRED_W-1:0] hred_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_mode_r <= dic_pkg::UNIT_CELSIUS;
    end else if (cfg_wr_en) begin
      unit_mode_r <= dic_pkg::unit_t'(cfg_wr_data);
    end
  end

  dic_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .out_ready (out_chan.ready),
    .en        (en),
    .in_ready  (in_chan.ready),
    .out_valid (out_valid)
  );

  dic_tconv u_tconv (
    .clk         (clk),
    .en          (en),
    .unit_mode   (unit_mode_r),
    .temperature (in_chan.temperature),
    .humidity    (in_chan.humidity),
    .t_o         (t2),
    .rh_o        (rh2)
  );

  dic_index u_index (
    .clk       (clk),
    .en        (en),
    .unit_mode (unit_mode_r),
    .t_i       (t2),
    .rh_i      (rh2),
    .div_n     (div_n),
    .div_d     (div_d),
    .res_o     (res)
  );

  dic_hdiv u_hdiv (
    .clk   (clk),
    .en    (en),
    .div_n (div_n),
    .div_d (div_d),
    .q_mag (h_mag),
    .q_neg (h_neg)
  );

  assign rh9  = {2'b0, res.rh};
  assign hm9  = {2'b0, h_mag};
  assign hred = h_neg ? rh9 + hm9 : rh9 - hm9;

  always_ff @(posedge clk) begin
    if (en[dic_pkg::NSTAGE-1]) begin
      di_r   <= res.di[dic_pkg::DI_W-1:0];
      band_r <= res.band;
      rv_r   <= res.rv;
      tred_r <= res.rv ? res.tred : '0;
      hred_r <= res.rv ? $signed(hred) : '0;
    end
  end

  assign out_chan.valid                 = out_valid;
  assign out_chan.discomfort_index      = di_r;
  assign out_chan.comfort_band          = band_r;
  assign out_chan.reduce_valid          = rv_r;
  assign out_chan.temperature_reduction = tred_r;
  assign out_chan.humidity_reduction    = hred_r;

endmodule

`default_nettype wire

/* src/dic_checker.sv */
// Port-level checks of the discomfort index classifier and their bind.
// Depends on dic_pkg and is attached to discomfort_index_classifier.
`default_nettype none

module dic_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [dic_pkg::DI_W-1:0]   discomfort_index,
  input wire logic [dic_pkg::BAND_W-1:0]        comfort_band,
  input wire logic                              reduce_valid,
  input wire logic signed [dic_pkg::TRED_W-1:0] temperature_reduction,
  input wire logic signed [dic_pkg::HRED_W-1:0] humidity_reduction
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(discomfort_index) &&
      $stable(comfort_band) && $stable(reduce_valid) &&
      $stable(temperature_reduction) && $stable(humidity_reduction))
    else $error("Stalled result changed or was dropped.");

  a_band_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> reduce_valid == (comfort_band != dic_pkg::BAND_NONE))
    else $error("Reduction flag disagrees with the comfort band.");

  a_no_discomfort: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !reduce_valid |-> discomfort_index <= 10'sd21 &&
      temperature_reduction == 11'sd0 && humidity_reduction == 9'sd0)
    else $error("Reductions given without discomfort.");

  a_emergency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && discomfort_index >= 10'sd32 |->
      comfort_band == dic_pkg::BAND_EMERGENCY)
    else $error("High index not flagged as emergency.");

endmodule

bind discomfort_index_classifier dic_checker u_dic_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_chan.valid),
  .out_ready             (out_chan.ready),
  .discomfort_index      (out_chan.discomfort_index),
  .comfort_band          (out_chan.comfort_band),
  .reduce_valid          (out_chan.reduce_valid),
  .temperature_reduction (out_chan.temperature_reduction),
  .humidity_reduction    (out_chan.humidity_reduction)
);

`default_nettype wire

/* sim/tb_discomfort_index_classifier.sv */
// Self-checking testbench for discomfort_index_classifier: directed table, then random readings.
// Expected results come from the table or an in-bench predictor of index, band and reductions.
// Depends on dic_pkg, dic_if and the RTL top level.
`default_nettype none

module tb_discomfort_index_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT    = 3000;
  localparam int HOLD_AT       = 400;
  localparam int HOLD_CYCLES   = 400;
  localparam int RAND_PHASES   = 4;
  localparam int PHASE_ITEMS   = 257;
  localparam int SETTLE_CYCLES = 2 * dic_pkg::NSTAGE;
  localparam int MAX_WAIT      = 18;

  typedef struct packed {
    logic signed [dic_pkg::DI_W-1:0]   di;
    dic_pkg::band_t                    band;
    logic                              rv;
    logic signed [dic_pkg::TRED_W-1:0] tred;
    logic signed [dic_pkg::HRED_W-1:0] hred;
  } comfort_t;

  typedef struct packed {
    dic_pkg::unit_t                    unit;
    logic signed [dic_pkg::TEMP_W-1:0] temp;
    logic [dic_pkg::HUM_W-1:0]         hum;
    logic                              known;
    comfort_t                          res;
  } reading_row_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  dic_in_if  in_if ();
  dic_out_if out_if ();

  discomfort_index_classifier u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  comfort_t       pending_q[$];
  reading_row_t   directed_q[$];
  dic_pkg::unit_t unit_mode = dic_pkg::UNIT_CELSIUS;
  int             errors = 0;
  int             reqs_sent = 0;
  int             results_checked = 0;
  int             reductions_seen = 0;
  int             unit_writes = 0;
  int             idle_cycles = 0;
  int             send_style = 0;
  logic [7:0]     bands_seen = '0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic comfort_t make_result(int di, dic_pkg::band_t band, logic rv, int tr,
                                           int hr);
    comfort_t r;
    r.di   = di[dic_pkg::DI_W-1:0];
    r.band = band;
    r.rv   = rv;
    r.tred = tr[dic_pkg::TRED_W-1:0];
    r.hred = hr[dic_pkg::HRED_W-1:0];
    return r;
  endfunction

  function automatic comfort_t predict_comfort(logic signed [dic_pkg::TEMP_W-1:0] temp,
                                               logic [dic_pkg::HUM_W-1:0] hum,
                                               dic_pkg::unit_t unit);
    int             t;
    int             rh;
    int             di;
    int             tr;
    int             hr;
    dic_pkg::band_t b;
    t  = int'(temp);
    rh = (hum > dic_pkg::HUM_MAX) ? 100 : int'(hum);
    if (unit == dic_pkg::UNIT_FAHRENHEIT) begin
      t = ((t - 32) * 5) / 9;
    end
    di = (4000 * t - 11 * (100 - rh) * (2 * t - 29)) / 4000;
    tr = 0;
    hr = 0;
    if (di > 21) begin
      tr = t - (260500 + 1595 * rh) / (9000 + 110 * rh);
      if (unit == dic_pkg::UNIT_FAHRENHEIT) begin
        tr = (tr * 9) / 5;
      end
      hr = rh - (52100 - 1800 * t) / (11 * (2 * t - 29));
    end
    if (di <= 21) begin
      b = dic_pkg::BAND_NONE;
    end else if (di < 24) begin
      b = dic_pkg::BAND_UNDER_HALF;
    end else if (di < 27) begin
      b = dic_pkg::BAND_OVER_HALF;
    end else if (di < 29) begin
      b = dic_pkg::BAND_MOST;
    end else if (di < 32) begin
      b = dic_pkg::BAND_ALL;
    end else begin
      b = dic_pkg::BAND_EMERGENCY;
    end
    return make_result(di, b, di > 21, tr, hr);
  endfunction

  function automatic int pick_wait(int style);
    int w;
    case (style)
      0:       w = $urandom_range(0, MAX_WAIT);
      1:       w = 0;
      default: w = $urandom_range(0, 2);
    endcase
    return w;
  endfunction

  function automatic int sender_gap();
    if (reqs_sent % 40 == 0) begin
      send_style = $urandom_range(0, 2);
    end
    return pick_wait(send_style);
  endfunction

  function automatic void draw_reading(output logic signed [dic_pkg::TEMP_W-1:0] temp,
                                       output logic [dic_pkg::HUM_W-1:0] hum);
    int          pick;
    int unsigned rt;
    int unsigned rh;
    pick = $urandom_range(0, 9);
    rh   = $urandom_range(0, 100);
    if (pick < 6) begin
      rt = (unit_mode == dic_pkg::UNIT_FAHRENHEIT) ? $urandom_range(40, 140) :
                                                      $urandom_range(5, 55);
    end else begin
      rt = $urandom;
    end
    if (pick == 8) begin
      rh = $urandom;
    end
    temp = rt[dic_pkg::TEMP_W-1:0];
    hum  = rh[dic_pkg::HUM_W-1:0];
    if (pick == 9) begin
      case ($urandom_range(0, 3))
        0:       temp = 10'h200;
        1:       temp = 10'h1ff;
        2:       temp = 10'h000;
        default: temp = 10'h3ff;
      endcase
      case ($urandom_range(0, 2))
        0:       hum = 7'd0;
        1:       hum = dic_pkg::HUM_MAX;
        default: hum = 7'h7f;
      endcase
    end
  endfunction

  task automatic add_row(dic_pkg::unit_t unit, int temp, int hum, logic known, comfort_t res);
    reading_row_t row;
    row.unit  = unit;
    row.temp  = temp[dic_pkg::TEMP_W-1:0];
    row.hum   = hum[dic_pkg::HUM_W-1:0];
    row.known = known;
    row.res   = res;
    directed_q.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic drive_reading(logic signed [dic_pkg::TEMP_W-1:0] temp,
                               logic [dic_pkg::HUM_W-1:0] hum,
                               logic known, comfort_t typed, int gap);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid       = 1'b1;
    in_if.temperature = temp;
    in_if.humidity    = hum;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_q.push_back(known ? typed : predict_comfort(temp, hum, unit_mode));
    reqs_sent++;
    @(negedge clk);
  endtask

  task automatic set_unit(dic_pkg::unit_t unit);
    in_if.valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = unit;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    unit_mode   = unit;
    unit_writes++;
  endtask

  task automatic report_mismatch(string what, comfort_t want, comfort_t got);
    errors++;
    if (errors <= 10) begin
      $display("%s at result %0d: expected di=%0d band=%0d rv=%0b tred=%0d hred=%0d",
               what, results_checked, want.di, want.band, want.rv, want.tred, want.hred);
      $display("    actual di=%0d band=%0d rv=%0b tred=%0d hred=%0d",
               got.di, got.band, got.rv, got.tred, got.hred);
    end
  endtask

  initial begin : stimulus
    logic signed [dic_pkg::TEMP_W-1:0] temp;
    logic [dic_pkg::HUM_W-1:0]         hum;
    reading_row_t                      row;
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = 1'b0;
    in_if.valid       = 1'b0;
    in_if.temperature = '0;
    in_if.humidity    = '0;

    // Saturated air makes the index equal the Celsius temperature.
    add_row(dic_pkg::UNIT_CELSIUS, 0, 100, 1'b1,
            make_result(0, dic_pkg::BAND_NONE, 1'b0, 0, 0));
    add_row(dic_pkg::UNIT_CELSIUS, -512, 100, 1'b1,
            make_result(-512, dic_pkg::BAND_NONE, 1'b0, 0, 0));
    add_row(dic_pkg::UNIT_CELSIUS, 511, 100, 1'b1,
            make_result(511, dic_pkg::BAND_EMERGENCY, 1'b1, 490, 179));
    add_row(dic_pkg::UNIT_CELSIUS, 511, 127, 1'b1,
            make_result(511, dic_pkg::BAND_EMERGENCY, 1'b1, 490, 179));
    add_row(dic_pkg::UNIT_CELSIUS, 21, 100, 1'b1,
            make_result(21, dic_pkg::BAND_NONE, 1'b0, 0, 0));
    add_row(dic_pkg::UNIT_CELSIUS, 22, 100, 1'b1,
            make_result(22, dic_pkg::BAND_UNDER_HALF, 1'b1, 1, 25));
    add_row(dic_pkg::UNIT_CELSIUS, 23, 100, 1'b0, '0);
    add_row(dic_pkg::UNIT_CELSIUS, 24, 100, 1'b0, '0);
    add_row(dic_pkg::UNIT_CELSIUS, 27, 100, 1'b0, '0);
    add_row(dic_pkg::UNIT_CELSIUS, 29, 100, 1'b0, '0);
    add_row(dic_pkg::UNIT_CELSIUS, 32, 100, 1'b1,
            make_result(32, dic_pkg::BAND_EMERGENCY, 1'b1, 11, 114));
    add_row(dic_pkg::UNIT_CELSIUS, 511, 0, 1'b0, '0);
    add_row(dic_pkg::UNIT_CELSIUS, -512, 0, 1'b0, '0);
    add_row(dic_pkg::UNIT_CELSIUS, 30, 50, 1'b0, '0);
    add_row(dic_pkg::UNIT_CELSIUS, 14, 101, 1'b0, '0);
    add_row(dic_pkg::UNIT_CELSIUS, 40, 64, 1'b0, '0);
    add_row(dic_pkg::UNIT_CELSIUS, -1, 0, 1'b0, '0);
    add_row(dic_pkg::UNIT_FAHRENHEIT, -512, 100, 1'b1,
            make_result(-302, dic_pkg::BAND_NONE, 1'b0, 0, 0));
    add_row(dic_pkg::UNIT_FAHRENHEIT, 511, 100, 1'b1,
            make_result(266, dic_pkg::BAND_EMERGENCY, 1'b1, 441, 177));
    add_row(dic_pkg::UNIT_FAHRENHEIT, 32, 100, 1'b1,
            make_result(0, dic_pkg::BAND_NONE, 1'b0, 0, 0));
    add_row(dic_pkg::UNIT_FAHRENHEIT, 31, 100, 1'b0, '0);
    add_row(dic_pkg::UNIT_FAHRENHEIT, 90, 40, 1'b0, '0);
    add_row(dic_pkg::UNIT_FAHRENHEIT, 100, 127, 1'b0, '0);
    add_row(dic_pkg::UNIT_FAHRENHEIT, 0, 0, 1'b0, '0);
    add_row(dic_pkg::UNIT_FAHRENHEIT, 85, 80, 1'b0, '0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The first rows run on the unit left by reset.
    foreach (directed_q[i]) begin
      row = directed_q[i];
      if (row.unit != unit_mode) begin
        set_unit(row.unit);
      end
      drive_reading(row.temp, row.hum, row.known, row.res, sender_gap());
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      set_unit((p % 2 == 1) ? dic_pkg::UNIT_FAHRENHEIT : dic_pkg::UNIT_CELSIUS);
      repeat (PHASE_ITEMS) begin
        draw_reading(temp, hum);
        drive_reading(temp, hum, 1'b0, '0, sender_gap());
      end
    end

    in_if.valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d requests and %0d results in both units (%0d unit writes),",
             reqs_sent, results_checked, unit_writes);
    $display("%0d results asked for reductions, bands seen %b, %0d mismatches.",
             reductions_seen, bands_seen[5:0], errors);
    if (errors == 0) begin
      $display("tb_discomfort_index_classifier: clean");
    end else begin
      $display("tb_discomfort_index_classifier: errors");
    end
    $finish;
  end

  initial begin : result_sink
    comfort_t got;
    comfort_t want;
    int       stall;
    int       style;
    style        = 0;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (results_checked % 50 == 0) begin
        style = $urandom_range(0, 2);
      end
      stall = pick_wait(style);
      // One long hold-off lets the pipeline fill and push back on requests.
      if (results_checked == HOLD_AT) begin
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready = 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      got = make_result(int'(out_if.discomfort_index),
                        dic_pkg::band_t'(out_if.comfort_band),
                        out_if.reduce_valid, int'(out_if.temperature_reduction),
                        int'(out_if.humidity_reduction));
      if (pending_q.size() == 0) begin
        report_mismatch("Unexpected result", '0, got);
      end else begin
        want = pending_q.pop_front();
        if (got.di !== want.di || got.band !== want.band || got.rv !== want.rv ||
            got.tred !== want.tred || got.hred !== want.hred) begin
          report_mismatch("Mismatch", want, got);
        end
      end
      results_checked++;
      if (got.rv === 1'b1) begin
        reductions_seen++;
      end
      bands_seen[got.band] = 1'b1;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Watchdog: nothing moved on either channel for %0d cycles", IDLE_LIMIT);
      $display("tb_discomfort_index_classifier: errors");
      $finish;
    end
  end

endmodule

`default_nettype wire
